@@ rtl/core/hrf_pkg.sv @@
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types and constants for the HID report framer: payload structs,
// configuration register indexes and the byte generator mode.
// ----------------------------------------------------------------------------
package hrf_pkg;

    // Report geometry
    localparam int REPORT_BYTES = 64;
    localparam int POS_W        = $clog2(REPORT_BYTES);

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CHANNEL = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TAG     = CFG_INDEX_W'(1);

    localparam logic [15:0] CHANNEL_RESET = 16'h0101;
    localparam logic [7:0]  TAG_RESET     = 8'h05;
    localparam logic [7:0]  PAD_BYTE      = 8'h00;

    // Header byte positions within a report
    localparam int HDR_W = 3;
    localparam logic [HDR_W-1:0] HDR_CHAN_HI = 3'd0;
    localparam logic [HDR_W-1:0] HDR_CHAN_LO = 3'd1;
    localparam logic [HDR_W-1:0] HDR_TAG     = 3'd2;
    localparam logic [HDR_W-1:0] HDR_SEQ_HI  = 3'd3;
    localparam logic [HDR_W-1:0] HDR_SEQ_LO  = 3'd4;
    localparam logic [HDR_W-1:0] HDR_LEN_HI  = 3'd5;
    localparam logic [HDR_W-1:0] HDR_LEN_LO  = 3'd6;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] message_length;
        logic        last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       report_end;
    } out_item_t;

    typedef struct packed {
        logic [15:0] channel_word;
        logic [7:0]  tag_byte;
    } cfg_t;

    typedef enum logic [1:0] {
        GEN_HEAD,
        GEN_DATA,
        GEN_PAD
    } gen_mode_t;

endpackage

@@ rtl/core/hid_report_framer_core.sv @@
// ----------------------------------------------------------------------------
// hid_report_framer_core
// Frames a byte message into fixed-size reports with header and zero padding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one message byte per
//   transfer, with the message length and a last-byte flag. Output channel
//   (out_valid / out_stall / out_data) delivers one report byte per transfer,
//   report_end marking the final byte of each report. Config writes
//   (cfg_valid / cfg_ready, always ready) set the channel word and tag byte.
//   Path: an input byte is taken into the holding register, and each report
//   byte is registered in the output register before it is offered.
//   Throughput: the byte generator emits one output byte per cycle while the
//   output is not stalled; an input byte occupies it for its data byte, plus
//   the header bytes when it opens a report and padding on the last byte.
//   Bytes inside a report sustain one input byte per cycle when not stalled.
//   The holding register takes the next input byte in the cycle the current
//   one emits its final output byte.
//   Reset: channel word 0x0101, tag 0x05, no message open.
//   Receiver stall: the output register holds its byte; the generator and
//   then the input channel stall behind it.
// ----------------------------------------------------------------------------
module hid_report_framer_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  hrf_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output hrf_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hrf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hrf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int POS_W = hrf_pkg::POS_W;

    hrf_pkg::cfg_t cfg;

    hrf_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Holding register and framing state
    hrf_pkg::in_item_t     hold_reg;
    logic                  hold_valid_reg, hold_valid_next;
    logic                  fresh_reg, fresh_next;
    hrf_pkg::gen_mode_t    mode_reg, mode_next;
    logic [hrf_pkg::HDR_W-1:0] hidx_reg, hidx_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [15:0]           seq_reg, seq_next;
    logic [15:0]           len_reg, len_next;
    logic                  open_reg, open_next;
    hrf_pkg::out_item_t    out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  start_w;
    logic [POS_W-1:0]      pos_c;
    logic [15:0]           seq_c;
    logic [15:0]           len_c;
    hrf_pkg::gen_mode_t    mode_c;
    logic [hrf_pkg::HDR_W-1:0] hidx_c;
    logic [POS_W:0]        pos_inc;
    logic                  end_w;
    logic                  emit_w;
    logic                  done_w;
    logic                  load_w;
    logic [7:0]            byte_w;

    // Generator advances when it holds a byte and the output register is free or draining
    assign emit_w = hold_valid_reg && (!out_valid_reg || !out_stall);
    assign load_w = in_valid && !in_stall;
    assign in_stall = hold_valid_reg && !(emit_w && done_w);

    // Effective state for this cycle, with message start applied
    assign start_w = fresh_reg && !open_reg;
    assign pos_c   = start_w ? '0 : pos_reg;
    assign seq_c   = start_w ? 16'd0 : seq_reg;
    assign len_c   = start_w ? hold_reg.message_length : len_reg;
    assign hidx_c  = fresh_reg ? hrf_pkg::HDR_CHAN_HI : hidx_reg;

    always_comb
    begin
        if (fresh_reg)
        begin
            mode_c = (pos_c == '0) ? hrf_pkg::GEN_HEAD : hrf_pkg::GEN_DATA;
        end
        else
        begin
            mode_c = mode_reg;
        end
    end

    assign pos_inc = {1'b0, pos_c} + (POS_W+1)'(1);
    assign end_w   = (pos_inc == (POS_W+1)'(hrf_pkg::REPORT_BYTES));

    // Select the byte to emit and the next generator step
    always_comb
    begin
        byte_w    = hrf_pkg::PAD_BYTE;
        mode_next = mode_c;
        hidx_next = hidx_c;
        done_w    = 1'b0;
        unique case (mode_c)
            hrf_pkg::GEN_HEAD:
            begin
                unique case (hidx_c)
                    hrf_pkg::HDR_CHAN_HI: byte_w = cfg.channel_word[15:8];
                    hrf_pkg::HDR_CHAN_LO: byte_w = cfg.channel_word[7:0];
                    hrf_pkg::HDR_TAG:     byte_w = cfg.tag_byte;
                    hrf_pkg::HDR_SEQ_HI:  byte_w = seq_c[15:8];
                    hrf_pkg::HDR_SEQ_LO:  byte_w = seq_c[7:0];
                    hrf_pkg::HDR_LEN_HI:  byte_w = len_c[15:8];
                    hrf_pkg::HDR_LEN_LO:  byte_w = len_c[7:0];
                    default:              byte_w = hrf_pkg::PAD_BYTE;
                endcase
                if ((hidx_c == hrf_pkg::HDR_SEQ_LO && seq_c != 16'd0) ||
                    hidx_c == hrf_pkg::HDR_LEN_LO)
                begin
                    mode_next = hrf_pkg::GEN_DATA;
                end
                else
                begin
                    hidx_next = hidx_c + hrf_pkg::HDR_W'(1);
                end
            end
            hrf_pkg::GEN_DATA:
            begin
                byte_w = hold_reg.data_byte;
                if (hold_reg.last_byte && !end_w)
                begin
                    mode_next = hrf_pkg::GEN_PAD;
                end
                else
                begin
                    done_w = 1'b1;
                end
            end
            hrf_pkg::GEN_PAD:
            begin
                byte_w = hrf_pkg::PAD_BYTE;
                done_w = end_w;
            end
            default:
            begin
                done_w = 1'b1;
            end
        endcase
    end

    // Update framing state on each emitted byte and each accepted input byte
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        fresh_next      = fresh_reg;
        pos_next        = pos_reg;
        seq_next        = seq_reg;
        len_next        = len_reg;
        open_next       = open_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (emit_w)
        begin
            fresh_next          = 1'b0;
            len_next            = len_c;
            pos_next            = end_w ? '0 : pos_inc[POS_W-1:0];
            seq_next            = end_w ? seq_c + 16'd1 : seq_c;
            open_next           = !(done_w && hold_reg.last_byte);
            out_next.out_byte   = byte_w;
            out_next.report_end = end_w;
            out_valid_next      = 1'b1;
            if (done_w)
            begin
                hold_valid_next = 1'b0;
            end
        end
        if (load_w)
        begin
            hold_valid_next = 1'b1;
            fresh_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            fresh_reg      <= 1'b0;
            mode_reg       <= hrf_pkg::GEN_HEAD;
            hidx_reg       <= hrf_pkg::HDR_CHAN_HI;
            pos_reg        <= '0;
            seq_reg        <= 16'd0;
            open_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            fresh_reg      <= fresh_next;
            if (emit_w)
            begin
                mode_reg <= mode_next;
                hidx_reg <= hidx_next;
            end
            pos_reg        <= pos_next;
            seq_reg        <= seq_next;
            open_reg       <= open_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_w)
        begin
            hold_reg <= in_data;
        end
        len_reg <= len_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_end_wraps_pos: assert property (@(posedge clk) disable iff (!rst_n)
        emit_w && end_w |=> pos_reg == '0)
        else $error("report end did not return position to zero");

    a_load_fills_hold: assert property (@(posedge clk) disable iff (!rst_n)
        load_w |=> hold_valid_reg && fresh_reg)
        else $error("accepted byte not held");

    a_pad_not_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && fresh_reg |-> mode_c != hrf_pkg::GEN_PAD)
        else $error("padding on a fresh byte");

    a_closed_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> pos_reg == '0)
        else $error("message closed inside a report");

endmodule

@@ rtl/core/hrf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hrf_cfg_regs
// Configuration register file: channel word and tag byte, written through a
// valid/ready channel. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module hrf_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hrf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hrf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output hrf_pkg::cfg_t                   cfg
);

    hrf_pkg::cfg_t cfg_reg;
    hrf_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index on a write transfer
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == hrf_pkg::CFG_IDX_CHANNEL)
            begin
                cfg_next.channel_word = cfg_data[15:0];
            end
            else if (cfg_index == hrf_pkg::CFG_IDX_TAG)
            begin
                cfg_next.tag_byte = cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_word <= hrf_pkg::CHANNEL_RESET;
            cfg_reg.tag_byte     <= hrf_pkg::TAG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
